// ===== design/oamdma_pkg.sv =====
// Shared types and constants for the sprite attribute DMA controller.
package oamdma_pkg;

	localparam int unsigned ATTR_BYTES = 160;

	localparam logic [15:0] MIRROR_BASE = 16'hE000;
	localparam logic [15:0] MIRROR_STEP = 16'h2000;
	localparam logic [1:0]  SETUP_TICKS = 2'd2;

	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 40;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

endpackage

// ===== design/oam_dma_controller_top.sv =====
// Sprite attribute DMA controller: register access and per-tick copy sequencing.
//
// Each input item is a source register write (tuser 0), a read (tuser 1) or one
// machine-cycle tick (tuser 2); code 3 is ignored but still answered. Every item
// yields exactly one result item. An item is taken into an input register and
// its result is computed by a single pass of logic into the output register, so
// one item is accepted per clock; the rate is set only by how fast the output
// side takes results. A write starts a transfer that copies after two ticks of
// setup, one byte per tick, for ATTR_BYTES ticks. A write during copying is
// held for two ticks and then restarts at index 0.
// Result addresses at or above E000 are mirrored down by 2000 hex.
module oam_dma_controller_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// write_value[7:0]
	input  logic [oamdma_pkg::IN_DATA_W-1:0]     s_tdata,
	// func[1:0]
	input  logic [oamdma_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// read_data[7:0], copy_valid[8], copy_address[24:9], copy_index[32:25],
	// transfer_active[33], zero fill[39:34]
	output logic [oamdma_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import oamdma_pkg::*;

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [7:0]  value_s1;
	logic        out_ok;
	logic        adv;

	logic        active_flag_q;
	logic [7:0]  source_high_q;
	logic [7:0]  byte_index_q;
	logic [1:0]  setup_ticks_q;
	logic        pending_flag_q;
	logic [7:0]  pending_source_high_q;
	logic [1:0]  pending_ticks_q;

	logic        active_d;
	logic [7:0]  source_d;
	logic [7:0]  index_d;
	logic [1:0]  setup_d;
	logic        pending_d;
	logic [7:0]  pend_src_d;
	logic [1:0]  pend_ticks_d;
	logic        cv;
	logic [15:0] raw_addr;
	logic [15:0] caddr;
	logic [7:0]  cidx;
	logic [8:0]  next_index;

	logic        out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign out_ok   = !out_valid_q || m_tready;
	assign adv      = valid_s1 && out_ok;
	assign s_tready = !valid_s1 || out_ok;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1  <= s_tuser;
			value_s1 <= s_tdata;
		end
	end

	assign raw_addr   = {source_high_q, byte_index_q};
	assign next_index = {1'b0, byte_index_q} + 9'd1;

	always_comb begin
		active_d     = active_flag_q;
		source_d     = source_high_q;
		index_d      = byte_index_q;
		setup_d      = setup_ticks_q;
		pending_d    = pending_flag_q;
		pend_src_d   = pending_source_high_q;
		pend_ticks_d = pending_ticks_q;
		cv           = 1'b0;
		caddr        = 16'd0;
		cidx         = 8'd0;
		case (func_s1)
			FUNC_WRITE: begin
				if (active_flag_q && setup_ticks_q == 2'd0) begin
					pending_d    = 1'b1;
					pend_src_d   = value_s1;
					pend_ticks_d = SETUP_TICKS;
				end else begin
					active_d     = 1'b1;
					source_d     = value_s1;
					index_d      = 8'd0;
					setup_d      = SETUP_TICKS;
					pending_d    = 1'b0;
					pend_ticks_d = 2'd0;
				end
			end
			FUNC_TICK: begin
				if (active_flag_q) begin
					if (setup_ticks_q != 2'd0) begin
						setup_d = setup_ticks_q - 2'd1;
					end else begin
						cv    = 1'b1;
						caddr = (raw_addr >= MIRROR_BASE) ? raw_addr - MIRROR_STEP : raw_addr;
						cidx  = byte_index_q;
						if (next_index >= 9'(ATTR_BYTES)) begin
							active_d = 1'b0;
						end
						index_d = next_index[7:0];
					end
				end
				if (pending_flag_q) begin
					pend_ticks_d = pending_ticks_q - 2'd1;
					if (pend_ticks_d == 2'd0) begin
						source_d  = pending_source_high_q;
						index_d   = 8'd0;
						setup_d   = 2'd0;
						active_d  = 1'b1;
						pending_d = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_flag_q         <= 1'b0;
			source_high_q         <= 8'hFF;
			byte_index_q          <= 8'd0;
			setup_ticks_q         <= 2'd0;
			pending_flag_q        <= 1'b0;
			pending_source_high_q <= 8'hFF;
			pending_ticks_q       <= 2'd0;
			out_valid_q           <= 1'b0;
		end else begin
			if (adv) begin
				active_flag_q         <= active_d;
				source_high_q         <= source_d;
				byte_index_q          <= index_d;
				setup_ticks_q         <= setup_d;
				pending_flag_q        <= pending_d;
				pending_source_high_q <= pend_src_d;
				pending_ticks_q       <= pend_ticks_d;
			end
			if (out_ok) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {6'd0, active_d || pending_d, cidx, caddr, cv, source_d};
		end
	end

	a_pending_count: assert property (@(posedge clk) disable iff (!arst_n)
		pending_flag_q |-> pending_ticks_q != 2'd0)
		else $error("pending request with expired wait");

	a_setup_active: assert property (@(posedge clk) disable iff (!arst_n)
		setup_ticks_q != 2'd0 |-> active_flag_q)
		else $error("setup counting while no transfer");

	a_copy_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[8] |-> out_data_q[32:25] < 8'(ATTR_BYTES - 1) + 8'd1
			|| ATTR_BYTES == 256)
		else $error("copy index beyond attribute memory");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_ok |=> valid_s1 && $stable(func_s1) && $stable(value_s1))
		else $error("input stage lost an item under stall");

	a_copy_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[8] && !out_data_q[33] |-> out_data_q[32:25] ==
			8'(ATTR_BYTES - 1))
		else $error("transfer ended before last byte");

endmodule
